@@ design/sha1s_pkg.sv @@
// Package for the SHA-1 stream hasher: field widths, payload types,
// initial chaining values and round constants. No dependencies.
package sha1s_pkg;

    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 3;
    localparam int NUM_WORDS = 5;
    localparam int ROUNDS    = 80;
    localparam int BLOCK_W   = 512;
    localparam int COUNT_W   = 64;
    localparam int FILL_W    = 6;
    localparam int ROUND_W   = 7;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [IDX_W-1:0]  t_word_idx;

    localparam t_word H_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam t_byte PAD_MARKER = 8'h80;

    // Offset in the block at which the 64-bit length field starts.
    localparam logic [FILL_W-1:0] LEN_OFFSET = 6'd56;
    localparam logic [FILL_W-1:0] FILL_LAST  = 6'd63;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'(ROUNDS - 1);
    localparam t_word_idx WORD_IDX_LAST = 3'(NUM_WORDS - 1);

endpackage

@@ design/sha1s_if.sv @@
// Stream interfaces of the SHA-1 hasher: byte input channel and digest
// output channel. Depends on sha1s_pkg.
interface sha1s_in_if
    import sha1s_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  has_byte;
    logic  end_of_message;

    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1s_out_if
    import sha1s_pkg::*;
;
    logic      valid;
    logic      ready;
    t_word     digest_word;
    t_word_idx word_index;
    logic      last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ design/sha1_stream_hasher.sv @@
// SHA-1 stream hasher top level: byte collection, padding sequencer and an
// iterative one-round-per-cycle compression unit. Depends on sha1s_pkg and
// the interfaces in sha1s_if.sv.
//
// Usage: message bytes arrive on i_in, one per transfer, with has_byte set.
// The final transfer of a message carries end_of_message; it may also carry
// a last byte, or none (has_byte clear), which is how an empty message ends.
// A transfer with both flags clear has no effect. After the end of a message
// the five digest words leave on o_out, word 0 (most significant) first,
// with last_word set on word 4, and the block is ready for a new message.
// The 64th byte of a block starts the compression unit, which runs one
// round per cycle and then adds the working variables into the chaining
// values. At the end of a message the padding is shifted in one byte per
// cycle (64 minus the bytes held) followed by one compression, or two when
// fewer than nine bytes of space remain; the digest words then follow.
// i_in.ready is low while compression, padding or digest output is under
// way. A stalled receiver simply holds the current digest word. Reset
// restores the initial chaining values and clears the byte and bit
// counts; the partly filled block buffer is left as it is.
module sha1_stream_hasher
    import sha1s_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha1s_in_if.sink          i_in,
    sha1s_out_if.source       o_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } t_state;

    t_state               r_state;
    t_word                r_h [NUM_WORDS];
    t_word                r_a, r_b, r_c, r_d, r_e;
    logic [BLOCK_W-1:0]   r_block;
    logic [COUNT_W-1:0]   r_count;
    logic [FILL_W-1:0]    r_fill;
    logic [ROUND_W-1:0]   r_round;
    t_word_idx            r_out_idx;
    logic                 r_pad_active;
    logic                 r_pad_first;
    logic                 r_last_block;

    t_word                w_cur;
    t_word                w_mix;
    t_word                w_new;
    t_word                f_val;
    t_word                k_val;
    t_word                t_val;
    t_byte                pad_byte;
    logic                 in_xfer;
    logic                 out_xfer;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = (r_state == ST_OUT);
    assign o_out.digest_word = r_h[r_out_idx];
    assign o_out.word_index  = r_out_idx;
    assign o_out.last_word   = (r_out_idx == WORD_IDX_LAST);

    // The block buffer is a shift line of sixteen words; the top word is the
    // schedule word of the current round and the word shifted in at the
    // bottom is the schedule word sixteen rounds ahead.
    always_comb begin
        w_cur = r_block[BLOCK_W-1 -: WORD_W];
        w_mix = r_block[BLOCK_W-1 -: WORD_W] ^ r_block[BLOCK_W-1-2*WORD_W -: WORD_W]
              ^ r_block[BLOCK_W-1-8*WORD_W -: WORD_W]
              ^ r_block[BLOCK_W-1-13*WORD_W -: WORD_W];
        w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};
    end

    always_comb begin
        if (r_round < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_0;
        end else if (r_round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_1;
        end else if (r_round < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_3;
        end
        t_val = {r_a[WORD_W-6:0], r_a[WORD_W-1 -: 5]} + f_val + r_e + k_val + w_cur;
    end

    // Padding byte for the current fill position: the marker first, then
    // zeros, and in the final block the bit count, most significant byte first.
    always_comb begin
        if (r_pad_first) begin
            pad_byte = PAD_MARKER;
        end else if (r_last_block && (r_fill >= LEN_OFFSET)) begin
            pad_byte = r_count[{~r_fill[2:0], 3'b000} +: BYTE_W];
        end else begin
            pad_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_h          <= H_INIT;
            r_count      <= '0;
            r_fill       <= '0;
            r_round      <= '0;
            r_out_idx    <= '0;
            r_pad_active <= 1'b0;
            r_pad_first  <= 1'b0;
            r_last_block <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (i_in.has_byte) begin
                            r_block <= {r_block[BLOCK_W-BYTE_W-1:0], i_in.data_byte};
                            r_count <= r_count + COUNT_W'(BYTE_W);
                            r_fill  <= r_fill + 1'b1;
                        end
                        if (i_in.end_of_message) begin
                            r_pad_active <= 1'b1;
                            r_pad_first  <= 1'b1;
                        end
                        if (i_in.has_byte && (r_fill == FILL_LAST)) begin
                            r_a     <= r_h[0];
                            r_b     <= r_h[1];
                            r_c     <= r_h[2];
                            r_d     <= r_h[3];
                            r_e     <= r_h[4];
                            r_round <= '0;
                            r_state <= ST_ROUND;
                        end else if (i_in.end_of_message) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_block <= {r_block[BLOCK_W-BYTE_W-1:0], pad_byte};
                    r_fill  <= r_fill + 1'b1;
                    if (r_pad_first) begin
                        // The length fits only when the marker lands before it.
                        r_last_block <= (r_fill < LEN_OFFSET);
                        r_pad_first  <= 1'b0;
                    end
                    if (r_fill == FILL_LAST) begin
                        r_a     <= r_h[0];
                        r_b     <= r_h[1];
                        r_c     <= r_h[2];
                        r_d     <= r_h[3];
                        r_e     <= r_h[4];
                        r_round <= '0;
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_block <= {r_block[BLOCK_W-WORD_W-1:0], w_new};
                    r_a     <= t_val;
                    r_b     <= r_a;
                    r_c     <= {r_b[1:0], r_b[WORD_W-1:2]};
                    r_d     <= r_c;
                    r_e     <= r_d;
                    r_round <= r_round + 1'b1;
                    if (r_round == ROUND_LAST) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    if (r_pad_active && !r_pad_first && r_last_block) begin
                        r_out_idx <= '0;
                        r_state   <= ST_OUT;
                    end else if (r_pad_active) begin
                        // Either padding has yet to start, or the marker
                        // spilled over and a length-only block follows.
                        r_last_block <= 1'b1;
                        r_state      <= ST_PAD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (out_xfer) begin
                        if (r_out_idx == WORD_IDX_LAST) begin
                            r_h          <= H_INIT;
                            r_count      <= '0;
                            r_fill       <= '0;
                            r_pad_active <= 1'b0;
                            r_last_block <= 1'b0;
                            r_out_idx    <= '0;
                            r_state      <= ST_IDLE;
                        end else begin
                            r_out_idx <= r_out_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while digest output is pending");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_round <= ROUND_LAST))
        else $error("round counter beyond the last round");

    a_digest_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_fill == '0 && !r_pad_first))
        else $error("digest output with a partly filled block");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out.last_word) |=>
            (r_h[0] == H_INIT[0] && r_count == '0 && r_state == ST_IDLE))
        else $error("hasher not restarted after the last digest word");

    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.word_index <= WORD_IDX_LAST))
        else $error("digest word index out of range");
`endif

endmodule

@@ dv/sha1_stream_hasher_test.sv @@
// Self-checking bench for sha1_stream_hasher: a short table of directed messages, then
// random messages, with every digest word checked against a table digest or a SHA-1 model kept in the bench.
// Depends on sha1s_pkg, the interfaces in sha1s_if.sv and the hasher itself.
module sha1_stream_hasher_test;
    import sha1s_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int TIMEOUT_UNITS   = 4_000_000;
    localparam int RANDOM_ITEMS    = 125;
    localparam int MIN_RANDOM_MSGS = 3;
    localparam int SETTLE_CYCLES   = 300;
    localparam int MAX_REPORTS     = 10;
    localparam int MAX_GAP         = 11;
    localparam int BLOCK_BYTES     = 64;

    typedef logic [0:NUM_WORDS-1][WORD_W-1:0] t_digest;

    typedef struct packed {
        t_word     value;
        t_word_idx index;
        logic      last;
    } t_digest_entry;

    typedef struct packed {
        t_byte   data;
        logic    has_byte;
        logic    eom;
        logic    known;
        t_digest digest;
    } t_directed_row;

    localparam t_digest DIGEST_EMPTY = {32'hDA39A3EE, 32'h5E6B4B0D, 32'h3255BFEF,
                                        32'h95601890, 32'hAFD80709};
    localparam t_digest DIGEST_ABC   = {32'hA9993E36, 32'h4706816A, 32'hBA3E2571,
                                        32'h7850C26C, 32'h9CD0D89D};
    localparam t_digest DIGEST_NONE  = '0;

    // Rows with known set carry a digest that can be checked by eye; the others are
    // left to the model.
    localparam int N_DIRECTED = 17;
    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},  // empty message straight after reset
        '{8'h61, 1'b1, 1'b0, 1'b0, DIGEST_NONE},
        '{8'h62, 1'b1, 1'b0, 1'b0, DIGEST_NONE},
        '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},    // last byte carries the end flag
        '{8'hA5, 1'b0, 1'b0, 1'b0, DIGEST_NONE},   // ignored item
        '{8'h00, 1'b1, 1'b0, 1'b0, DIGEST_NONE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, DIGEST_NONE},
        '{8'h5A, 1'b0, 1'b0, 1'b0, DIGEST_NONE},
        '{8'h00, 1'b0, 1'b1, 1'b0, DIGEST_NONE},   // end without a byte, non-empty message
        '{8'hFF, 1'b1, 1'b1, 1'b0, DIGEST_NONE},
        '{8'h00, 1'b1, 1'b1, 1'b0, DIGEST_NONE},
        '{8'hC3, 1'b0, 1'b0, 1'b0, DIGEST_NONE},
        '{8'h7E, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},  // data is ignored without has_byte
        '{8'h61, 1'b1, 1'b0, 1'b0, DIGEST_NONE},
        '{8'h00, 1'b0, 1'b0, 1'b0, DIGEST_NONE},
        '{8'h62, 1'b1, 1'b0, 1'b0, DIGEST_NONE},
        '{8'h63, 1'b1, 1'b0, 1'b0, DIGEST_NONE}
    };

    logic i_clk;
    logic i_rst_n;

    sha1s_in_if  byte_ch ();
    sha1s_out_if digest_ch ();

    sha1_stream_hasher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (digest_ch)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Hash state mirrored in the bench.
    t_word         chain_h [NUM_WORDS];
    t_byte         block_buf [BLOCK_BYTES];
    int unsigned   fill_count;
    logic [COUNT_W-1:0] bit_length;

    t_digest_entry digest_due [$];
    int            failure_count  = 0;
    int            counted_items  = 0;
    int            in_quiet_run   = 0;
    int            out_quiet_run  = 0;

    function automatic t_word rotl(input t_word v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic void compress_block_bytes();
        t_word w [ROUNDS];
        t_word a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        end
        for (int i = 16; i < ROUNDS; i++) begin
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int i = 0; i < ROUNDS; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = K_0;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = K_1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end else begin
                f = b ^ c ^ d;
                k = K_3;
            end
            t = rotl(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < NUM_WORDS; i++) begin
            chain_h[i] = H_INIT[i];
        end
        fill_count = 0;
        bit_length = '0;
    endfunction

    // Absorbs one accepted item; returns 1 with the digest when the item ends a message.
    function automatic bit absorb_item(input t_byte d, input logic hb, input logic eom,
                                       output t_digest digest);
        int pos;
        digest = DIGEST_NONE;
        if (hb) begin
            block_buf[fill_count] = d;
            bit_length += COUNT_W'(8);
            fill_count = (fill_count + 1) % BLOCK_BYTES;
            if (fill_count == 0) begin
                compress_block_bytes();
            end
        end
        if (!eom) begin
            return 1'b0;
        end
        // Marker, zeros up to the length field, spilling into a second block when the
        // marker leaves no room for the 64-bit length.
        pos = fill_count;
        block_buf[pos] = PAD_MARKER;
        pos++;
        if (pos > LEN_OFFSET) begin
            while (pos < BLOCK_BYTES) begin
                block_buf[pos] = '0;
                pos++;
            end
            compress_block_bytes();
            pos = 0;
        end
        while (pos < LEN_OFFSET) begin
            block_buf[pos] = '0;
            pos++;
        end
        for (int i = 0; i < 8; i++) begin
            block_buf[LEN_OFFSET + i] = bit_length[COUNT_W-1-8*i -: 8];
        end
        compress_block_bytes();
        for (int i = 0; i < NUM_WORDS; i++) begin
            digest[i] = chain_h[i];
        end
        restart_message();
        return 1'b1;
    endfunction

    // Idle cycles before the next transfer; now and then a run of back-to-back transfers.
    function automatic int draw_gap(inout int quiet_run);
        if (quiet_run > 0) begin
            quiet_run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_run = $urandom_range(5, 30);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic send_item(input t_byte d, input logic hb, input logic eom,
                             input logic known, input t_digest known_digest);
        int      gap;
        t_digest digest;
        gap = draw_gap(in_quiet_run);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid          <= 1'b1;
        byte_ch.data_byte      <= d;
        byte_ch.has_byte       <= hb;
        byte_ch.end_of_message <= eom;
        do @(posedge i_clk); while (!byte_ch.ready);
        if (absorb_item(d, hb, eom, digest)) begin
            if (known) begin
                digest = known_digest;
            end
            for (int i = 0; i < NUM_WORDS; i++) begin
                digest_due.push_back('{value: digest[i], index: t_word_idx'(i),
                                       last: (i == NUM_WORDS - 1)});
            end
        end
        if (hb || eom) begin
            counted_items++;
        end
    endtask

    // One random message; the end comes either on the last byte or as a separate item.
    task automatic send_message(input int len);
        bit split_end;
        split_end = (len == 0) || ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(t_byte'($urandom), 1'b0, 1'b0, 1'b0, DIGEST_NONE);
            end
            send_item(t_byte'($urandom), 1'b1, (i == len - 1) && !split_end, 1'b0, DIGEST_NONE);
        end
        if (split_end) begin
            send_item(t_byte'($urandom), 1'b0, 1'b1, 1'b0, DIGEST_NONE);
        end
    endtask

    // Digest receiver: random stalls, each transfer compared with the oldest expectation.
    initial begin
        t_digest_entry got;
        t_digest_entry want;
        int            gap;
        digest_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = draw_gap(out_quiet_run);
            if (gap > 0) begin
                digest_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            digest_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!digest_ch.valid);
            got = '{value: digest_ch.digest_word, index: digest_ch.word_index,
                    last: digest_ch.last_word};
            if (digest_due.size() == 0) begin
                failure_count++;
                if (failure_count <= MAX_REPORTS) begin
                    $display("unexpected digest word %h index %0d last %b",
                             got.value, got.index, got.last);
                end
            end else begin
                want = digest_due.pop_front();
                if (got.value !== want.value || got.index !== want.index ||
                    got.last !== want.last) begin
                    failure_count++;
                    if (failure_count <= MAX_REPORTS) begin
                        $display("mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                                 want.value, want.index, want.last,
                                 got.value, got.index, got.last);
                    end
                end
            end
        end
    end

    initial begin
        int msgs;
        int len;
        int start_items;
        i_rst_n                <= 1'b0;
        byte_ch.valid          <= 1'b0;
        byte_ch.data_byte      <= '0;
        byte_ch.has_byte       <= 1'b0;
        byte_ch.end_of_message <= 1'b0;
        restart_message();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_item(DIRECTED[r].data, DIRECTED[r].has_byte, DIRECTED[r].eom,
                      DIRECTED[r].known, DIRECTED[r].digest);
        end

        // The directed table leaves "abc" open; close it with a byteless end.
        send_item(8'h00, 1'b0, 1'b1, 1'b1, DIGEST_ABC);

        // Random part: first a message that needs a second padding block and one that
        // fills a block exactly, then mostly short messages with some around 64 bytes.
        start_items = counted_items;
        send_message(56);
        send_message(BLOCK_BYTES);
        msgs = 2;
        while (counted_items - start_items < RANDOM_ITEMS || msgs < MIN_RANDOM_MSGS) begin
            if ($urandom_range(0, 5) == 0) begin
                len = $urandom_range(55, 66);
            end else begin
                len = $urandom_range(0, 9);
            end
            send_message(len);
            msgs++;
        end
        byte_ch.valid <= 1'b0;

        while (digest_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failure_count == 0 && digest_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_UNITS;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
design/sha1s_pkg.sv
design/sha1s_if.sv
design/sha1_stream_hasher.sv
dv/sha1_stream_hasher_test.sv
